// ===== sv/vhf_pkg.sv =====
package vhf_pkg;

   // Fixed link and message geometry.
   localparam int unsigned MTU_BYTES     = 20;
   localparam int unsigned MAX_FRAGMENTS = 4096;
   localparam int unsigned MAX_RESULTS   = 6;

   // Field widths.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned INDEX_W  = 12;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned LIMIT_W  = 13;
   localparam int unsigned VER_W    = 4;
   localparam int unsigned FILL_W   = 8;
   localparam int unsigned COUNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = LIMIT_W;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAGMENT_LIMIT   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PROTOCOL_VERSION = 1'b1;

   // Register reset values.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(4096);
   localparam logic [VER_W-1:0]   VERSION_RESET = VER_W'(3);

   // Derived constants in the widths where they are compared.
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(MAX_FRAGMENTS);
   localparam logic [FILL_W:0]    MTU_CMP   = (FILL_W + 1)'(MTU_BYTES);

   // Varint encoding: seven payload bits per byte, top bit flags continuation.
   localparam int unsigned  VARINT_BITS  = 7;
   localparam logic         VARINT_MORE  = 1'b1;
   localparam logic         VARINT_STOP  = 1'b0;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [COUNT_W-1:0] count_type;

   // One output byte with its side information.
   typedef struct packed {
      byte_type  out_byte;
      index_type fragment_index;
      logic      fragment_end;
      logic      message_end;
      logic      overflow_error;
   } result_type;

   // All results caused by one input beat.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] entries;
      count_type                    count;
   } burst_type;

   // One accepted input beat.
   typedef struct packed {
      byte_type data_byte;
      len_type  message_length;
   } item_type;

endpackage

// ===== sv/vhf_frame.sv =====
module vhf_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  vhf_pkg::item_type             item,
   input  logic [vhf_pkg::LIMIT_W-1:0]   fragment_limit,
   input  logic [vhf_pkg::VER_W-1:0]     protocol_version,
   output vhf_pkg::burst_type            burst
);

   // Message framing state.
   vhf_pkg::index_type              frag_count_ff,  frag_count_in;
   logic [vhf_pkg::FILL_W-1:0]      fill_level_ff,  fill_level_in;
   vhf_pkg::len_type                bytes_taken_ff, bytes_taken_in;
   vhf_pkg::len_type                msg_total_ff,   msg_total_in;
   logic                            dropping_ff,    dropping_in;

   // Decode of the current beat against the state.
   logic                            first;
   logic                            opening;
   logic                            overflow;
   logic                            last;
   logic                            frag_end;
   logic [vhf_pkg::LEN_W:0]         bytes_next;
   vhf_pkg::len_type                total;
   logic [vhf_pkg::LIMIT_W-1:0]     limit_eff;
   logic [vhf_pkg::LIMIT_W-1:0]     new_index;
   vhf_pkg::index_type              cur_index;
   logic                            index_more;
   logic [1:0]                      len_bytes;
   vhf_pkg::byte_type               len_b0, len_b1, len_b2, ver_byte;
   vhf_pkg::byte_type               hdr [vhf_pkg::MAX_RESULTS];
   vhf_pkg::count_type              hdr_n;
   logic [vhf_pkg::FILL_W-1:0]      fill_base;
   logic [vhf_pkg::FILL_W:0]        fill_inc;

   // Classify the beat: message start, fragment start, overflow, last byte.
   always_comb begin
      first      = (bytes_taken_ff == '0);
      total      = first ? ((item.message_length == '0) ? vhf_pkg::LEN_W'(1)
                                                        : item.message_length)
                         : msg_total_ff;
      bytes_next = {1'b0, bytes_taken_ff} + (vhf_pkg::LEN_W + 1)'(1);
      last       = (bytes_next >= {1'b0, total});
      limit_eff  = (fragment_limit > vhf_pkg::LIMIT_MAX) ? vhf_pkg::LIMIT_MAX
                                                         : fragment_limit;
      new_index  = first ? '0 : ({1'b0, frag_count_ff} + vhf_pkg::LIMIT_W'(1));
      opening    = first || (fill_level_ff == '0);
      overflow   = opening && (new_index >= limit_eff);
      cur_index  = opening ? new_index[vhf_pkg::INDEX_W-1:0] : frag_count_ff;
   end

   // Header bytes: index varint, then on fragment zero length varint and version.
   always_comb begin
      index_more = (new_index[vhf_pkg::INDEX_W-1:vhf_pkg::VARINT_BITS] != '0);
      len_b0     = {(total[15:7] != '0) ? vhf_pkg::VARINT_MORE : vhf_pkg::VARINT_STOP,
                    total[6:0]};
      len_b1     = {(total[15:14] != '0) ? vhf_pkg::VARINT_MORE : vhf_pkg::VARINT_STOP,
                    total[13:7]};
      len_b2     = {6'b0, total[15:14]};
      ver_byte   = {protocol_version, 4'b0};
      len_bytes  = (total[15:14] != '0) ? 2'd3 : ((total[15:7] != '0) ? 2'd2 : 2'd1);
      for (int k = 0; k < vhf_pkg::MAX_RESULTS; k++) begin
         hdr[k] = '0;
      end
      hdr_n = '0;
      if (first) begin
         // Fragment zero: index byte 0, length varint, version byte.
         hdr[0] = '0;
         hdr[1] = len_b0;
         unique case (len_bytes)
            2'd3: begin
               hdr[2] = len_b1;
               hdr[3] = len_b2;
               hdr[4] = ver_byte;
               hdr_n  = vhf_pkg::COUNT_W'(5);
            end
            2'd2: begin
               hdr[2] = len_b1;
               hdr[3] = ver_byte;
               hdr_n  = vhf_pkg::COUNT_W'(4);
            end
            default: begin
               hdr[2] = ver_byte;
               hdr_n  = vhf_pkg::COUNT_W'(3);
            end
         endcase
      end else if (opening) begin
         hdr[0] = {index_more ? vhf_pkg::VARINT_MORE : vhf_pkg::VARINT_STOP,
                   new_index[6:0]};
         hdr[1] = {3'b0, new_index[vhf_pkg::INDEX_W-1:vhf_pkg::VARINT_BITS]};
         hdr_n  = index_more ? vhf_pkg::COUNT_W'(2) : vhf_pkg::COUNT_W'(1);
      end
   end

   // Fill level after this data byte and whether it closes the fragment.
   always_comb begin
      fill_base = opening ? vhf_pkg::FILL_W'(hdr_n) : fill_level_ff;
      fill_inc  = {1'b0, fill_base} + (vhf_pkg::FILL_W + 1)'(1);
      frag_end  = last || (fill_inc >= vhf_pkg::MTU_CMP);
   end

   // Assemble the result list for this beat.
   always_comb begin
      for (int k = 0; k < vhf_pkg::MAX_RESULTS; k++) begin
         if (vhf_pkg::COUNT_W'(k) < hdr_n) begin
            burst.entries[k] = '{out_byte: hdr[k], fragment_index: cur_index,
                                 fragment_end: 1'b0, message_end: 1'b0,
                                 overflow_error: 1'b0};
         end else begin
            burst.entries[k] = '{out_byte: item.data_byte, fragment_index: cur_index,
                                 fragment_end: frag_end, message_end: last,
                                 overflow_error: 1'b0};
         end
      end
      burst.count = hdr_n + vhf_pkg::COUNT_W'(1);
      if (dropping_ff) begin
         burst.count = '0;
      end else if (overflow) begin
         burst.entries[0] = '{out_byte: '0, fragment_index: '0, fragment_end: 1'b0,
                              message_end: 1'b1, overflow_error: 1'b1};
         burst.count      = vhf_pkg::COUNT_W'(1);
      end
   end

   // Next state when the beat is taken.
   always_comb begin
      frag_count_in  = frag_count_ff;
      fill_level_in  = fill_level_ff;
      bytes_taken_in = bytes_taken_ff;
      msg_total_in   = msg_total_ff;
      dropping_in    = dropping_ff;
      if (load) begin
         bytes_taken_in = bytes_next[vhf_pkg::LEN_W-1:0];
         if (!dropping_ff) begin
            msg_total_in = total;
         end
         if (dropping_ff || overflow) begin
            dropping_in = 1'b1;
         end else begin
            frag_count_in = cur_index;
            fill_level_in = frag_end ? '0 : fill_inc[vhf_pkg::FILL_W-1:0];
         end
         if (last) begin
            bytes_taken_in = '0;
            frag_count_in  = '0;
            fill_level_in  = '0;
            dropping_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frag_count_ff  <= '0;
         fill_level_ff  <= '0;
         bytes_taken_ff <= '0;
         msg_total_ff   <= '0;
         dropping_ff    <= 1'b0;
      end else begin
         frag_count_ff  <= frag_count_in;
         fill_level_ff  <= fill_level_in;
         bytes_taken_ff <= bytes_taken_in;
         msg_total_ff   <= msg_total_in;
         dropping_ff    <= dropping_in;
      end
   end

endmodule

// ===== sv/vhf_burst.sv =====
module vhf_burst (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  vhf_pkg::burst_type    burst,
   output logic                  free,
   output vhf_pkg::result_type   result,
   output logic                  result_valid,
   output logic                  result_last,
   input  logic                  result_ready
);

   vhf_pkg::result_type [vhf_pkg::MAX_RESULTS-1:0] entries_ff, entries_in;
   vhf_pkg::count_type                             count_ff,   count_in;
   vhf_pkg::count_type                             pos_ff,     pos_in;
   logic                                           busy_ff,    busy_in;
   logic                                           fire;

   // Present the current entry; the last one of the list carries the run mark.
   always_comb begin
      result       = entries_ff[pos_ff[vhf_pkg::COUNT_W-1:0]];
      result_valid = busy_ff;
      result_last  = (pos_ff == (count_ff - vhf_pkg::COUNT_W'(1)));
      fire         = busy_ff && result_ready;
      free         = !busy_ff || (fire && result_last);
   end

   // Step through the list, reloading as soon as the final beat leaves.
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      busy_in    = busy_ff;
      if (load) begin
         entries_in = burst.entries;
         count_in   = burst.count;
         pos_in     = '0;
         busy_in    = (burst.count != '0);
      end else if (fire) begin
         if (result_last) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + vhf_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      count_ff   <= count_in;
      if (reset) begin
         pos_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         busy_ff <= busy_in;
      end
   end

   // The read pointer stays inside the loaded list.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < count_ff))
      else $error("burst pointer beyond list");

   // A new list is never loaded over one that still has beats to send.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !(fire && result_last)) |-> !load)
      else $error("burst overwritten while busy");

   // An overflow result stands alone and ends its run and its message.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && result.overflow_error) |-> (result_last && result.message_end))
      else $error("overflow result not alone");

   // The message end always closes a fragment on data beats.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && result.message_end && !result.overflow_error) |-> result.fragment_end)
      else $error("message end without fragment end");

endmodule

// ===== sv/varint_header_fragmenter.sv =====
// Message fragmenter: takes one payload byte per req beat (the message length is
// sampled on a message's first byte) and emits the fragment stream on rsp, one
// byte per beat. Each fragment opens with its index as a base-128 varint; fragment
// zero adds the length varint and a version byte. Throughput is one data byte per
// cycle while rsp does not stall; a message's first byte gives up to 6 rsp beats,
// a later fragment's up to 3, as rsp sends one header or data byte per cycle.
// Beats of a dropped message are taken and emit nothing. Each req beat is held in the
// input register, then the result list register. fragment_limit and protocol_version
// are written through csr_* by the user only while idle; the block does not enforce it.
module varint_header_fragmenter (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // data_byte, message_length
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // out_byte, fragment_index,
                                                         // fragment_end, message_end, pad
   output logic                              rsp_tlast,  // run_last
   output logic                              rsp_tuser,  // overflow_error
   // Configuration writes.
   input  logic                              csr_we,
   input  logic [vhf_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [vhf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   vhf_pkg::item_type               item_ff, item_in;
   logic                            item_valid_ff, item_valid_in;
   logic [vhf_pkg::LIMIT_W-1:0]     limit_ff, limit_in;
   logic [vhf_pkg::VER_W-1:0]       version_ff, version_in;
   logic                            load;
   logic                            free;
   vhf_pkg::burst_type              burst;
   vhf_pkg::result_type             result;

   // Input register: refilled in the same cycle it hands its beat on.
   always_comb begin
      load          = item_valid_ff && free;
      req_tready    = !item_valid_ff || free;
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_tvalid && req_tready) begin
         item_in       = '{data_byte: req_tdata[7:0], message_length: req_tdata[23:8]};
         item_valid_in = 1'b1;
      end else if (load) begin
         item_valid_in = 1'b0;
      end
   end

   // Configuration registers.
   always_comb begin
      limit_in   = limit_ff;
      version_in = version_ff;
      if (csr_we) begin
         unique case (csr_addr)
            vhf_pkg::CSR_FRAGMENT_LIMIT:   limit_in   = csr_wdata;
            vhf_pkg::CSR_PROTOCOL_VERSION: version_in = csr_wdata[vhf_pkg::VER_W-1:0];
            default:                       limit_in   = limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         item_valid_ff <= 1'b0;
         limit_ff      <= vhf_pkg::LIMIT_RESET;
         version_ff    <= vhf_pkg::VERSION_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         limit_ff      <= limit_in;
         version_ff    <= version_in;
      end
   end

   // Framing state and per-beat result list.
   vhf_frame u_frame (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .item             (item_ff),
      .fragment_limit   (limit_ff),
      .protocol_version (version_ff),
      .burst            (burst)
   );

   // Result list register and output sequencing.
   vhf_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .burst        (burst),
      .free         (free),
      .result       (result),
      .result_valid (rsp_tvalid),
      .result_last  (rsp_tlast),
      .result_ready (rsp_tready)
   );

   // Pack the result beat.
   always_comb begin
      rsp_tdata = {2'b0, result.message_end, result.fragment_end,
                   result.fragment_index, result.out_byte};
      rsp_tuser = result.overflow_error;
   end

endmodule

// ===== bench/varint_header_fragmenter_tb.sv =====
module varint_header_fragmenter_tb;
   import vhf_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned PARTIAL_BEATS = 18;

   // One expected output byte together with its end-of-step marker.
   typedef struct packed {
      result_type res;
      logic       run_last;
   } frag_byte_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;  // data_byte, message_length
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;  // out_byte, fragment_index, fragment_end,
                                      // message_end, pad
   logic                  rsp_tlast;  // run_last
   logic                  rsp_tuser;  // overflow_error
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_FRAGMENT_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Mirror of the block's registers and message state.
   logic [LIMIT_W-1:0] cfg_limit = LIMIT_RESET;
   logic [VER_W-1:0]   cfg_version = VERSION_RESET;
   index_type          open_fragment = '0;
   int unsigned        fill_count = 0;
   int unsigned        taken_count = 0;
   int unsigned        length_total = 0;
   logic               discarding = 1'b0;

   frag_byte_type  expected_bytes[$];
   frag_byte_type  staged_bytes[$];
   int unsigned errors = 0;
   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   varint_header_fragmenter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stage one output byte of the current step.
   function automatic void stage_byte(input byte_type b, input index_type idx,
                                      input logic frag_end, input logic msg_end,
                                      input logic ovf);
      frag_byte_type e;
      e.res.out_byte       = b;
      e.res.fragment_index = idx;
      e.res.fragment_end   = frag_end;
      e.res.message_end    = msg_end;
      e.res.overflow_error = ovf;
      e.run_last           = 1'b0;
      staged_bytes.push_back(e);
   endfunction

   // Base-128 encoding, low group first, top bit set while more groups follow.
   function automatic void stage_varint(input int unsigned value, input index_type idx);
      byte_type b;
      do begin
         b = byte_type'(value & 32'h7F);
         value = value >> 7;
         if (value != 0) b[7] = 1'b1;
         stage_byte(b, idx, 1'b0, 1'b0, 1'b0);
      end while (value != 0);
   endfunction

   // Mark the last staged byte and move the step's bytes to the expected queue.
   function automatic void release_staged();
      staged_bytes[staged_bytes.size()-1].run_last = 1'b1;
      foreach (staged_bytes[i]) expected_bytes.push_back(staged_bytes[i]);
      staged_bytes.delete();
   endfunction

   function automatic void close_message();
      taken_count   = 0;
      open_fragment = '0;
      fill_count    = 0;
      discarding    = 1'b0;
   endfunction

   // Work out the fragment bytes that one accepted payload beat produces.
   function automatic void fragment_message_byte(input byte_type data, input len_type length);
      int unsigned limit;
      int unsigned new_index;
      logic        opening;
      logic        last_byte;
      logic        closes;
      limit     = (cfg_limit > LIMIT_MAX) ? MAX_FRAGMENTS : int'(cfg_limit);
      new_index = 0;
      opening   = 1'b0;

      // Rest of an overflowed message is swallowed silently.
      if (discarding) begin
         taken_count++;
         if (taken_count >= length_total) close_message();
         return;
      end

      if (taken_count == 0) begin
         length_total = (length == 0) ? 1 : int'(length);
         opening = 1'b1;
      end else if (fill_count == 0) begin
         new_index = int'(open_fragment) + 1;
         opening = 1'b1;
      end

      if (opening) begin
         // A fragment beyond the limit gives one overflow byte and drops the rest.
         if (new_index >= limit) begin
            stage_byte('0, '0, 1'b0, 1'b1, 1'b1);
            release_staged();
            taken_count++;
            if (taken_count >= length_total) close_message();
            else discarding = 1'b1;
            return;
         end
         open_fragment = index_type'(new_index);
         stage_varint(new_index, open_fragment);
         if (new_index == 0) begin
            stage_varint(length_total, open_fragment);
            stage_byte({cfg_version, 4'h0}, open_fragment, 1'b0, 1'b0, 1'b0);
         end
         fill_count = staged_bytes.size();
      end

      taken_count++;
      fill_count++;
      last_byte = (taken_count >= length_total);
      closes    = last_byte || (fill_count >= MTU_BYTES);
      stage_byte(data, open_fragment, closes, last_byte, 1'b0);
      if (closes) fill_count = 0;
      if (last_byte) close_message();
      release_staged();
   endfunction

   // Result side: ready pattern, with long hold-offs on request.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Compare each result beat with the oldest expected byte.
   always @(posedge clock) begin
      frag_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual data=%h last=%b user=%b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata[7:0] !== want.res.out_byte ||
                rsp_tdata[19:8] !== want.res.fragment_index ||
                rsp_tdata[20] !== want.res.fragment_end ||
                rsp_tdata[21] !== want.res.message_end ||
                rsp_tuser !== want.res.overflow_error ||
                rsp_tlast !== want.run_last) begin
               errors++;
               $display("%0t: mismatch, expected byte=%h idx=%0d fe=%b me=%b ovf=%b last=%b",
                        $time, want.res.out_byte, want.res.fragment_index,
                        want.res.fragment_end, want.res.message_end,
                        want.res.overflow_error, want.run_last);
               $display("%0t:           actual byte=%h idx=%0d fe=%b me=%b ovf=%b last=%b",
                        $time, rsp_tdata[7:0], rsp_tdata[19:8], rsp_tdata[20],
                        rsp_tdata[21], rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // Watchdog on cycles in which neither stream moves a beat.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL varint_header_fragmenter");
            $finish;
         end
      end
   end

   // Offer one payload beat, with an optional idle gap first.
   task automatic send_beat(input byte_type data, input len_type length);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {length, data};
      do @(posedge clock); while (!req_tready);
      fragment_message_byte(data, length);
   endtask

   // A whole message of random bytes; the length field is noise after the first beat.
   task automatic send_message(input len_type length);
      int unsigned beats;
      beats = (length == 0) ? 1 : int'(length);
      for (int unsigned i = 0; i < beats; i++) begin
         send_beat(byte_type'($urandom_range(255)),
                   (i == 0) ? length : len_type'($urandom_range(65535)));
      end
   endtask

   // Let every expected byte arrive, then allow the pipeline to settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [LIMIT_W-1:0] limit,
                               input logic [VER_W-1:0] version);
      logic [CSR_DATA_W-1:0] ver_word;
      ver_word = CSR_DATA_W'($urandom);
      ver_word[VER_W-1:0] = version;
      csr_we    <= 1'b1;
      csr_addr  <= CSR_FRAGMENT_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_addr  <= CSR_PROTOCOL_VERSION;
      csr_wdata <= ver_word;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_limit   = limit;
      cfg_version = version;
   endtask

   function automatic logic [LIMIT_W-1:0] pick_limit();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) return LIMIT_W'($urandom_range(1, 4));
      if (r < 55) return LIMIT_W'(0);
      if (r < 70) return LIMIT_MAX;
      if (r < 80) return '1;
      return LIMIT_W'($urandom_range(1, 8191));
   endfunction

   function automatic len_type pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)  return '0;
      if (r < 70) return len_type'($urandom_range(1, 8));
      if (r < 95) return len_type'($urandom_range(9, 24));
      return len_type'($urandom_range(25, 45));
   endfunction

   // Reset register values: single-byte, zero-length and MTU-crossing messages.
   task automatic test_reset_config();
      send_beat(8'h00, 16'd1);
      send_beat(8'hFF, 16'd0);
      send_beat(8'hA5, 16'd21);
      for (int i = 1; i < 21; i++) send_beat(byte_type'(8'h5A ^ i), 16'hFFFF);
      wait_drained();
   endtask

   // Register extremes: limit of one, limit of zero, limit above the maximum.
   task automatic test_config_extremes();
      write_config(LIMIT_W'(1), 4'hF);
      send_message(16'd20);
      wait_drained();
      write_config(LIMIT_W'(0), 4'h0);
      send_message(16'd3);
      send_message(16'd1);
      wait_drained();
      write_config('1, 4'h0);
      send_message(16'd25);
      wait_drained();
   endtask

   // Largest length: six results from the first beat, then overflow and dropped beats.
   // The message stays open, so this runs last.
   task automatic test_max_length_drop();
      write_config(LIMIT_W'(1), 4'h9);
      send_beat(byte_type'($urandom_range(255)), 16'hFFFF);
      for (int i = 1; i < PARTIAL_BEATS; i++) begin
         send_beat(byte_type'($urandom_range(255)), len_type'($urandom_range(65535)));
      end
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      write_config(LIMIT_MAX, 4'hC);
      hold_request = HOLD_CYCLES;
      send_message(16'd20);
      send_message(16'd5);
      wait_drained();
   endtask

   // Random messages under a few random register settings.
   task automatic test_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int k = 0; k < 2; k++) begin
         wait_drained();
         write_config(pick_limit(), VER_W'($urandom_range(15)));
         for (int n = 0; n < 4; ) begin
            len_type length;
            length = pick_length();
            send_message(length);
            n += (length == 0) ? 1 : int'(length);
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_config_extremes();
      test_backpressure();
      test_random_phase(15, 48);
      test_random_phase(48, 15);
      test_random_phase(0, 0);
      test_max_length_drop();

      // Catch any stray beats after the last expected one.
      rx_idle_pct = 0;
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("PASS varint_header_fragmenter");
      end else begin
         $display("FAIL varint_header_fragmenter");
      end
      $finish;
   end

endmodule
